// ----- design/surng_pkg.sv -----
// Package: constants, state type and helpers of the subtractive uniform generator.
package surng_pkg;

    localparam int TABLE_DEPTH = 55;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 30;
    localparam int SEED_W      = 29;
    localparam int PASS_W      = 2;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0]  FILL_STRIDE = IDX_W'(21);
    localparam logic [IDX_W-1:0]  WARM_LAG    = IDX_W'(31);
    localparam logic [IDX_W-1:0]  LAG_START   = IDX_W'(30);
    localparam logic [PASS_W-1:0] LAST_PASS   = PASS_W'(4 - 1);

    localparam logic [VAL_W:0]    MOD_BIG     = (VAL_W+1)'(1000000000);
    localparam logic [SEED_W-1:0] SEED_BASE   = SEED_W'(161803398);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_TOP,
        ST_FILL,
        ST_WARM_RD,
        ST_WARM_WR,
        ST_DRAW_RD,
        ST_DRAW
    } state_t;

    // Index advance with wrap at the end of the table.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

endpackage

// ----- design/subtractive_uniform_rng.sv -----
// Top level: lagged subtractive generator with one shared modular subtractor.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+------------------------------------
//  command  | seed                     | beat taken when start & !busy
//  result   | deviate, seed_out        | one-cycle beat marked by done
//
// A plain draw does one memory read of both entries, then one subtract and
// write-back. A reseeding draw runs the accept cycle, 1 top write, 54 fill
// steps, then 4 x 55 warm-up steps (read, then subtract/write) through the
// single table port pair, then a read and the draw.
// Reset clears control state only; the table holds nothing until the first
// item, which always seeds. The receiver cannot stall; done is a strobe.
module subtractive_uniform_rng (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [surng_pkg::SEED_W-1:0]   seed,
    output logic                                  done,
    output logic        [surng_pkg::VAL_W-1:0]    deviate,
    output logic signed [surng_pkg::SEED_W-1:0]   seed_out
);
    import surng_pkg::*;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  read_index_reg, read_index_next;
    logic [IDX_W-1:0]  lag_index_reg,  lag_index_next;
    logic              seeded_reg,     seeded_next;
    logic [IDX_W-1:0]  step_reg,       step_next;
    logic [IDX_W-1:0]  lagp_reg,       lagp_next;
    logic [IDX_W-1:0]  p21_reg,        p21_next;
    logic [PASS_W-1:0] pass_reg,       pass_next;
    logic [VAL_W-1:0]  cur_reg,        cur_next;
    logic [VAL_W-1:0]  prev_reg,       prev_next;
    logic [SEED_W-1:0] seed_hold_reg,  seed_hold_next;
    logic [VAL_W-1:0]  deviate_reg,    deviate_next;
    logic              done_reg,       done_next;

    logic [VAL_W-1:0]  lag_table_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]  rd_a_reg, rd_b_reg;

    logic              accept;
    logic              reseed;
    logic [SEED_W-1:0] magnitude;
    logic [SEED_W-1:0] mag_sat;
    logic [IDX_W-1:0]  ri_inc, li_inc;
    logic [IDX_W:0]    p21_sum;
    logic [IDX_W-1:0]  fill_pos;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  raddr_a, raddr_b;
    logic              use_fill_ops;

    logic [VAL_W-1:0]  sub_a, sub_b, sub_res;
    logic [VAL_W:0]    sub_wrap;

    assign accept    = start && (state_reg == ST_IDLE);
    assign reseed    = seed[SEED_W-1] || !seeded_reg;
    assign magnitude = seed[SEED_W-1] ? (~seed + SEED_W'(1)) : seed;
    assign mag_sat   = (magnitude > SEED_BASE) ? SEED_BASE : magnitude;

    assign ri_inc = idx_inc(read_index_reg);
    assign li_inc = idx_inc(lag_index_reg);

    // 21*i mod 55 walk for the fill order; entry is one below it, wrapping.
    assign p21_sum  = {1'b0, p21_reg} + {1'b0, FILL_STRIDE};
    assign fill_pos = (p21_reg == '0) ? LAST_IDX : p21_reg - IDX_W'(1);

    // shared modular subtractor
    assign sub_a    = use_fill_ops ? cur_reg  : rd_a_reg;
    assign sub_b    = use_fill_ops ? prev_reg : rd_b_reg;
    assign sub_wrap = {1'b0, sub_a} + MOD_BIG - {1'b0, sub_b};
    assign sub_res  = (sub_a >= sub_b) ? (sub_a - sub_b) : sub_wrap[VAL_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = reseed ? ST_SEED_TOP : ST_DRAW;
                end
            end
            ST_SEED_TOP: state_next = ST_FILL;
            ST_FILL:
            begin
                if (step_reg == LAST_IDX)
                begin
                    state_next = ST_WARM_RD;
                end
            end
            ST_WARM_RD: state_next = ST_WARM_WR;
            ST_WARM_WR:
            begin
                if (step_reg == LAST_IDX && pass_reg == LAST_PASS)
                begin
                    state_next = ST_DRAW_RD;
                end
                else
                begin
                    state_next = ST_WARM_RD;
                end
            end
            ST_DRAW_RD: state_next = ST_DRAW;
            ST_DRAW:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port and subtractor operand control
    always_comb
    begin
        mem_we       = 1'b0;
        mem_waddr    = step_reg;
        mem_wdata    = sub_res;
        raddr_a      = step_reg;
        raddr_b      = lagp_reg;
        use_fill_ops = 1'b0;
        case (state_reg)
            ST_IDLE, ST_DRAW_RD:
            begin
                raddr_a = ri_inc;
                raddr_b = li_inc;
            end
            ST_SEED_TOP:
            begin
                mem_we    = 1'b1;
                mem_waddr = LAST_IDX;
                mem_wdata = cur_reg;
            end
            ST_FILL:
            begin
                mem_we       = 1'b1;
                mem_waddr    = fill_pos;
                mem_wdata    = prev_reg;
                use_fill_ops = 1'b1;
            end
            ST_WARM_WR:
            begin
                mem_we = 1'b1;
            end
            ST_DRAW:
            begin
                mem_we    = 1'b1;
                mem_waddr = ri_inc;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        read_index_next = read_index_reg;
        lag_index_next  = lag_index_reg;
        seeded_next     = seeded_reg;
        step_next       = step_reg;
        lagp_next       = lagp_reg;
        p21_next        = p21_reg;
        pass_next       = pass_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        seed_hold_next  = seed_hold_reg;
        deviate_next    = deviate_reg;
        done_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    seeded_next    = 1'b1;
                    seed_hold_next = reseed ? SEED_W'(1) : seed;
                    cur_next       = VAL_W'(SEED_BASE - mag_sat);
                    prev_next      = VAL_W'(1);
                end
            end
            ST_SEED_TOP:
            begin
                step_next = IDX_W'(1);
                p21_next  = FILL_STRIDE;
            end
            ST_FILL:
            begin
                prev_next = sub_res;
                cur_next  = prev_reg;
                p21_next  = (p21_sum >= (IDX_W+1)'(TABLE_DEPTH))
                            ? IDX_W'(p21_sum - (IDX_W+1)'(TABLE_DEPTH))
                            : p21_sum[IDX_W-1:0];
                if (step_reg == LAST_IDX)
                begin
                    step_next = '0;
                    lagp_next = WARM_LAG;
                    pass_next = '0;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_WARM_WR:
            begin
                step_next = idx_inc(step_reg);
                lagp_next = idx_inc(lagp_reg);
                if (step_reg == LAST_IDX)
                begin
                    pass_next = pass_reg + PASS_W'(1);
                    if (pass_reg == LAST_PASS)
                    begin
                        read_index_next = LAST_IDX;
                        lag_index_next  = LAG_START;
                    end
                end
            end
            ST_DRAW:
            begin
                read_index_next = ri_inc;
                lag_index_next  = li_inc;
                deviate_next    = sub_res;
                done_next       = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            read_index_reg <= '0;
            lag_index_reg  <= '0;
            seeded_reg     <= 1'b0;
            step_reg       <= '0;
            lagp_reg       <= '0;
            p21_reg        <= '0;
            pass_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            lag_index_reg  <= lag_index_next;
            seeded_reg     <= seeded_next;
            step_reg       <= step_next;
            lagp_reg       <= lagp_next;
            p21_reg        <= p21_next;
            pass_reg       <= pass_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        seed_hold_reg <= seed_hold_next;
        deviate_reg   <= deviate_next;
    end

    // lag table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lag_table_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= lag_table_mem[raddr_a];
        rd_b_reg <= lag_table_mem[raddr_b];
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign deviate  = deviate_reg;
    assign seed_out = seed_hold_reg;

`ifndef SYNTHESIS
    a_done_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_DRAW) && (state_reg == ST_IDLE))
        else $error("result strobe without a draw step");

    a_first_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !seeded_reg) |=> (state_reg == ST_SEED_TOP))
        else $error("first item after reset did not seed the table");

    a_lag_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (seeded_reg && state_reg == ST_IDLE) |->
        (lag_index_reg == ((read_index_reg >= IDX_W'(24))
                           ? read_index_reg - IDX_W'(24)
                           : read_index_reg + WARM_LAG)))
        else $error("lag index lost its offset from the read index");

    a_deviate_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ({1'b0, deviate_reg} < MOD_BIG))
        else $error("draw out of modulus range");
`endif

endmodule

// ----- sim/subtractive_uniform_rng_test.sv -----
// Testbench for the subtractive uniform generator: directed and random seed beats checked against a predictor.
`timescale 1ns / 1ps

module subtractive_uniform_rng_test;
    import surng_pkg::*;

    localparam int unsigned DRAW_MOD    = 1000000000;
    localparam int unsigned BASE_VALUE  = 161803398;
    localparam int          FILL_STEP   = 21;
    localparam int          WARMUP_LAG  = 31;
    localparam int          FIRST_LAG   = 30;
    localparam int          WARMUP_RUNS = 4;
    localparam int          STALL_LIMIT = 4000;
    localparam int          SETTLE_CYC  = 500;
    localparam int          ITEM_TARGET = 1650;

    typedef struct {
        bit                        drain;
        logic signed [SEED_W-1:0]  seed;
        int                        gap;
    } seed_cmd_t;

    typedef struct {
        logic        [VAL_W-1:0]   deviate;
        logic signed [SEED_W-1:0]  seed_out;
    } draw_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic signed [SEED_W-1:0]   seed  = '0;
    logic                       busy;
    logic                       done;
    logic        [VAL_W-1:0]    deviate;
    logic signed [SEED_W-1:0]   seed_out;

    seed_cmd_t pending_seeds[$];
    draw_t     expected_draws[$];

    // predictor state
    logic [VAL_W-1:0] lag_ring [TABLE_DEPTH];
    int               rd_pos;
    int               lag_pos;
    bit               ring_seeded;

    int fail_count;
    int draws_checked;
    int reseed_count;
    int saturate_count;
    int gap_left;
    int launch_gap;
    int idle_cycles;

    subtractive_uniform_rng u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .seed     (seed),
        .done     (done),
        .deviate  (deviate),
        .seed_out (seed_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [VAL_W-1:0] mod_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        if (a >= b)
            return a - b;
        return VAL_W'(32'(a) + DRAW_MOD - 32'(b));
    endfunction

    function automatic int step_pos(input int i);
        return (i == TABLE_DEPTH - 1) ? 0 : i + 1;
    endfunction

    // Advance the generator by one seed beat and return the draw it must produce.
    task automatic draw_from_seed(input logic signed [SEED_W-1:0] s, output draw_t res);
        logic [SEED_W-1:0] mag;
        logic [VAL_W-1:0]  cur;
        logic [VAL_W-1:0]  prev;
        int                pos;

        res.seed_out = s;
        if (s[SEED_W-1] || !ring_seeded)
        begin
            mag = s;
            if (s[SEED_W-1])
                mag = ~mag + 1'b1;
            if (mag > BASE_VALUE)
            begin
                mag = SEED_W'(BASE_VALUE);
                saturate_count++;
            end
            cur = VAL_W'(BASE_VALUE - mag);
            lag_ring[TABLE_DEPTH-1] = cur;
            prev = VAL_W'(1);
            // scattered fill, stride 21 through the ring
            for (int i = 1; i < TABLE_DEPTH; i++)
            begin
                pos = (FILL_STEP * i) % TABLE_DEPTH;
                pos = (pos == 0) ? TABLE_DEPTH - 1 : pos - 1;
                lag_ring[pos] = prev;
                prev = mod_diff(cur, prev);
                cur = lag_ring[pos];
            end
            for (int p = 0; p < WARMUP_RUNS; p++)
                for (int i = 0; i < TABLE_DEPTH; i++)
                    lag_ring[i] = mod_diff(lag_ring[i],
                                           lag_ring[(i + WARMUP_LAG) % TABLE_DEPTH]);
            rd_pos = TABLE_DEPTH - 1;
            lag_pos = FIRST_LAG;
            ring_seeded = 1'b1;
            reseed_count++;
            res.seed_out = SEED_W'(1);
        end
        rd_pos = step_pos(rd_pos);
        lag_pos = step_pos(lag_pos);
        lag_ring[rd_pos] = mod_diff(lag_ring[rd_pos], lag_ring[lag_pos]);
        res.deviate = lag_ring[rd_pos];
    endtask

    task automatic queue_seed(input logic signed [SEED_W-1:0] s, input int g);
        pending_seeds.push_back('{drain: 1'b0, seed: s, gap: g});
    endtask

    function automatic logic signed [SEED_W-1:0] neg_seed(input int unsigned m);
        return -SEED_W'(m);
    endfunction

    // Driver: one seed beat at a time, gap drawn per beat.
    always @(posedge clk)
    begin
        seed_cmd_t nxt;
        logic      go;

        if (rst_n)
        begin
            go = start;
            if (start && !busy)
            begin
                draw_t d;
                draw_from_seed(seed, d);
                expected_draws.push_back(d);
                go = 1'b0;
                gap_left = launch_gap;
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_seeds.size() > 0)
                begin
                    if (pending_seeds[0].drain)
                    begin
                        // hold off until the block has delivered everything
                        if (expected_draws.size() == 0)
                            void'(pending_seeds.pop_front());
                    end
                    else
                    begin
                        nxt = pending_seeds.pop_front();
                        seed <= nxt.seed;
                        launch_gap = nxt.gap;
                        go = 1'b1;
                    end
                end
            end
            start <= go;
        end
    end

    // Monitor: every done beat must match the oldest expected draw.
    always @(posedge clk)
    begin
        draw_t want;

        if (rst_n && done)
        begin
            if (expected_draws.size() == 0)
            begin
                $error("unexpected result: deviate %0d seed_out %0d", deviate, seed_out);
                fail_count++;
            end
            else
            begin
                want = expected_draws.pop_front();
                draws_checked++;
                if (deviate !== want.deviate)
                begin
                    $error("deviate: expected %0d, got %0d", want.deviate, deviate);
                    fail_count++;
                end
                if (seed_out !== want.seed_out)
                begin
                    $error("seed_out: expected %0d, got %0d", want.seed_out, seed_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without progress", idle_cycles);
            $display("subtractive_uniform_rng: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int  total;
        int  run_len;
        bit  burst;
        int  pick;

        fail_count = 0;
        draws_checked = 0;
        reseed_count = 0;
        saturate_count = 0;
        gap_left = 0;
        launch_gap = 0;
        idle_cycles = 0;
        ring_seeded = 1'b0;
        rd_pos = 0;
        lag_pos = 0;

        // directed: first beat above the base, zero, extremes, saturation
        queue_seed(SEED_W'((1 << 28) - 1), 0);
        queue_seed(SEED_W'(0), $urandom_range(0, 6));
        queue_seed(SEED_W'(BASE_VALUE), $urandom_range(0, 6));
        queue_seed(neg_seed(1), 0);
        queue_seed(SEED_W'(5), $urandom_range(0, 6));
        queue_seed(neg_seed(BASE_VALUE), 0);
        queue_seed(SEED_W'(1), 0);
        queue_seed(neg_seed(1 << 28), $urandom_range(0, 6));
        queue_seed(neg_seed(BASE_VALUE + 1), 0);
        pending_seeds.push_back('{drain: 1'b1, seed: '0, gap: 0});
        queue_seed(neg_seed(BASE_VALUE - 1), 0);
        queue_seed(SEED_W'((1 << 28) - 1), 0);
        queue_seed(SEED_W'(12345), $urandom_range(0, 6));
        queue_seed(SEED_W'(BASE_VALUE + 1), 0);
        queue_seed(neg_seed(12345), 0);
        queue_seed(SEED_W'(0), 0);
        total = pending_seeds.size() - 1;

        // random: runs of plain draws, mostly opened by a reseed, some noise
        while (total < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(20, 120);
            if ($urandom_range(0, 9) == 0)
                pending_seeds.push_back('{drain: 1'b1, seed: '0, gap: 0});
            pick = $urandom_range(0, 9);
            if (pick < 8)
                queue_seed(neg_seed($urandom_range(1, BASE_VALUE)),
                           burst ? 0 : $urandom_range(0, 6));
            else if (pick == 8)
                queue_seed(neg_seed($urandom_range(BASE_VALUE + 1, 1 << 28)),
                           burst ? 0 : $urandom_range(0, 6));
            else
                queue_seed(SEED_W'($urandom_range(0, (1 << 28) - 1)), 0);
            total++;
            for (int i = 0; i < run_len && total < ITEM_TARGET; i++)
            begin
                if ($urandom_range(0, 32) == 0)
                    queue_seed(neg_seed($urandom_range(1, 1 << 28)),
                               burst ? 0 : $urandom_range(0, 6));
                else
                    queue_seed(SEED_W'($urandom_range(0, (1 << 28) - 1)),
                               burst ? 0 : $urandom_range(0, 6));
                total++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_seeds.size() > 0 || start || expected_draws.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("checked %0d draws, %0d of them reseeding the table", draws_checked,
                 reseed_count);
        $display("seed magnitude clamped to the base on %0d reseeds", saturate_count);
        if (fail_count == 0)
            $display("subtractive_uniform_rng: match");
        else
            $display("subtractive_uniform_rng: mismatch");
        $finish;
    end

endmodule
